[rtl/hbsf_pkg.sv]
// Shared types and constants for the HDLC bit-stuffing framer.
package hbsf_pkg;

   // Line flag sent before and after each frame body
   localparam logic [7:0] FLAG_PATTERN = 8'h7E;
   // Consecutive body ones that force a stuffed zero
   localparam logic [2:0] STUFF_LIMIT = 3'd5;
   // Largest valid bit count of one input beat
   localparam logic [3:0] BYTE_BITS = 4'd8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified body item as held in the queue
   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] bit_count;
      logic       frame_first;
      logic       frame_last;
   } hbsf_item_type;

   // Write side of the queue
   typedef struct packed {
      logic          valid;
      hbsf_item_type item;
   } hbsf_push_type;

   // Queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } hbsf_queue_stat_type;

endpackage

[rtl/hbsf_req_if.sv]
// Input channel: one body byte per beat with valid-bit count and frame marks.
interface hbsf_req_if;
   import hbsf_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [3:0] bit_count;
   logic       frame_first;
   logic       frame_last;

   modport source(output valid, output data_byte, output bit_count,
                  output frame_first, output frame_last, input ready);
   modport sink(input valid, input data_byte, input bit_count,
                input frame_first, input frame_last, output ready);
endinterface

[rtl/hbsf_rsp_if.sv]
// Result channel: one serial line bit per beat.
interface hbsf_rsp_if;
   import hbsf_pkg::*;

   logic valid;
   logic ready;
   logic line_bit;
   logic run_end;

   modport source(output valid, output line_bit, output run_end, input ready);
   modport sink(input valid, input line_bit, input run_end, output ready);
endinterface

[rtl/hbsf_front.sv]
// Front end: accept input beats, clamp the bit count, drop beats with no line output.
module hbsf_front (
   hbsf_req_if.sink                   req_ch,
   input  hbsf_pkg::hbsf_queue_stat_type qstat,
   output hbsf_pkg::hbsf_push_type       push
);
   import hbsf_pkg::*;

   logic       accept;
   logic [3:0] count_clamped;
   logic       no_output;

   // Take a beat whenever the queue has room
   assign req_ch.ready = !qstat.full;
   assign accept       = req_ch.valid && !qstat.full;

   // Clamp counts above a full byte
   assign count_clamped = (req_ch.bit_count > BYTE_BITS) ? BYTE_BITS : req_ch.bit_count;

   // A beat with no bits and no flags emits nothing and leaves the run count alone
   assign no_output = (count_clamped == 4'd0) && !req_ch.frame_first && !req_ch.frame_last;

   // Queue the classified item
   always_comb begin
      push.valid            = accept && !no_output;
      push.item.data_byte   = req_ch.data_byte;
      push.item.bit_count   = count_clamped;
      push.item.frame_first = req_ch.frame_first;
      push.item.frame_last  = req_ch.frame_last;
   end
endmodule

[rtl/hbsf_queue.sv]
// Short item queue between the front end and the serializer.
module hbsf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  hbsf_pkg::hbsf_push_type       push,
   input  logic                          pop,
   output hbsf_pkg::hbsf_item_type       head,
   output hbsf_pkg::hbsf_queue_stat_type stat
);
   import hbsf_pkg::*;

   hbsf_item_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   fill_ff, fill_in;
   logic                     do_push;
   logic                     do_pop;

   assign stat.full  = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign head       = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !stat.full;
   assign do_pop  = pop && !stat.empty;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end
endmodule

[rtl/hbsf_back.sv]
// Back end: serialize flags and stuffed body bits, one line bit per beat.
module hbsf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  hbsf_pkg::hbsf_item_type       head,
   input  hbsf_pkg::hbsf_queue_stat_type qstat,
   output logic                          pop,
   hbsf_rsp_if.source                    rsp_ch
);
   import hbsf_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_OPEN  = 3'd1;
   localparam logic [2:0] PH_BODY  = 3'd2;
   localparam logic [2:0] PH_STUFF = 3'd3;
   localparam logic [2:0] PH_CLOSE = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [2:0] idx_ff, idx_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic [2:0] ones_ff, ones_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       line_bit_ff, line_bit_in;
   logic       run_end_ff, run_end_in;

   logic       adv;
   logic       active;
   logic       emit;
   logic       fin;
   logic       load;
   logic       cur_bit;
   logic [2:0] ones_inc;

   // Phase that follows the body once its remaining count is known
   function automatic logic [2:0] after_body(input logic [3:0] cnt, input logic last);
      logic [2:0] ph;
      if (cnt != 4'd0) begin
         ph = PH_BODY;
      end else if (last) begin
         ph = PH_CLOSE;
      end else begin
         ph = PH_IDLE;
      end
      return ph;
   endfunction

   // Output register moves when empty or taken
   assign adv    = !rsp_valid_ff || rsp_ch.ready;
   assign active = (phase_ff != PH_IDLE);
   assign emit   = active && adv;

   // Step the serializer and load the next item
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      ones_in  = ones_ff;
      cur_bit  = 1'b0;
      ones_inc = ones_ff + 3'd1;

      if (emit) begin
         unique case (phase_ff)
            PH_OPEN: begin
               cur_bit = FLAG_PATTERN[3'd7 - idx_ff];
               idx_in  = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  phase_in = after_body(cnt_ff, last_ff);
               end
            end
            PH_BODY: begin
               cur_bit = data_ff[7];
               data_in = {data_ff[6:0], 1'b0};
               cnt_in  = cnt_ff - 4'd1;
               if (data_ff[7]) begin
                  ones_in = ones_inc;
               end else begin
                  ones_in = 3'd0;
               end
               if (data_ff[7] && (ones_inc == STUFF_LIMIT)) begin
                  phase_in = PH_STUFF;
               end else begin
                  phase_in = after_body(cnt_in, last_ff);
               end
            end
            PH_STUFF: begin
               cur_bit  = 1'b0;
               ones_in  = 3'd0;
               phase_in = after_body(cnt_ff, last_ff);
            end
            PH_CLOSE: begin
               cur_bit = FLAG_PATTERN[3'd7 - idx_ff];
               idx_in  = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  ones_in  = 3'd0;
                  phase_in = PH_IDLE;
               end
            end
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      fin  = emit && (phase_in == PH_IDLE);
      load = (!active || fin) && !qstat.empty;

      if (load) begin
         data_in = head.data_byte;
         cnt_in  = head.bit_count;
         last_in = head.frame_last;
         idx_in  = 3'd0;
         if (head.frame_first) begin
            ones_in  = 3'd0;
            phase_in = PH_OPEN;
         end else begin
            phase_in = (head.bit_count != 4'd0) ? PH_BODY : PH_CLOSE;
         end
      end
   end

   assign pop = load;

   // Fill the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      line_bit_in  = line_bit_ff;
      run_end_in   = run_end_ff;
      if (adv) begin
         rsp_valid_in = emit;
         line_bit_in  = cur_bit;
         run_end_in   = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         ones_ff      <= 3'd0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ones_ff      <= ones_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      line_bit_ff <= line_bit_in;
      run_end_ff  <= run_end_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.line_bit = line_bit_ff;
   assign rsp_ch.run_end  = run_end_ff;
endmodule

[rtl/hdlc_bit_stuffing_framer.sv]
// Top level of the HDLC zero-bit-insertion framer.
//
// The req_ch channel takes one beat per body byte: data_byte (sent from
// bit 7 down), bit_count (0 to 8 valid bits, larger counts act as 8),
// frame_first and frame_last. The rsp_ch channel delivers the line one bit
// per beat; run_end marks the last bit produced for an input beat.
// A first beat is preceded by the flag 01111110 and a last beat followed by
// the same flag; in the body a zero follows every fifth consecutive one, the
// run count carrying over from beat to beat.
// The front end queues up to 4 beats; the serializer emits one line bit per
// cycle while rsp_ch does not stall, and a beat yields bit_count body bits,
// its stuffed zeros and 8 bits per flag. An accepted beat passes through the
// queue, the serializer state and the output register on its way to rsp_ch,
// and the next queued beat follows its predecessor's last bit without a gap.
// Beats with no bits and no flags are taken and produce nothing.
// Reset empties the queue and the output register and clears the run count.
// When rsp_ch stalls the output bit holds, the serializer waits, and req_ch
// keeps accepting until the queue fills.
module hdlc_bit_stuffing_framer (
   input logic        clock,
   input logic        reset,
   hbsf_req_if.sink   req_ch,
   hbsf_rsp_if.source rsp_ch
);
   import hbsf_pkg::*;

   hbsf_push_type       push;
   hbsf_queue_stat_type qstat;
   hbsf_item_type       head;
   logic                pop;

   hbsf_front u_front (
      .req_ch (req_ch),
      .qstat  (qstat),
      .push   (push)
   );

   hbsf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (qstat)
   );

   hbsf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .qstat  (qstat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );
endmodule

[rtl/hbsf_checker.sv]
// Port-level checks for the framer, bound to the top level.
module hbsf_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic line_bit,
   input logic run_end
);
   logic [2:0] ones_seen_ff, ones_seen_in;
   logic       beat;

   assign beat = rsp_valid && rsp_ready;

   // Count consecutive delivered ones on the line
   always_comb begin
      ones_seen_in = ones_seen_ff;
      if (beat) begin
         ones_seen_in = line_bit ? ones_seen_ff + 3'd1 : 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_seen_ff <= 3'd0;
      end else begin
         ones_seen_ff <= ones_seen_in;
      end
   end

   // Reset leaves nothing to deliver
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Reset leaves the queue empty and open for input
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready right after reset");

   // A stalled beat holds its bit and its end mark
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_bit) && $stable(run_end))
      else $error("stalled response changed");

   // Only a flag carries six ones; seven in a row means stuffing failed
   a_no_seven_ones: assert property (@(posedge clock) disable iff (reset)
      beat && line_bit |-> ones_seen_ff < 3'd6)
      else $error("seven consecutive ones on the line");
endmodule

bind hdlc_bit_stuffing_framer hbsf_checker u_hbsf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .line_bit  (rsp_ch.line_bit),
   .run_end   (rsp_ch.run_end)
);

[tb/testbench.sv]
// Self-checking testbench for the HDLC bit-stuffing framer.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hbsf_pkg::*;

   // One queued input beat, with an option to wait for the line to drain first
   typedef struct {
      hbsf_item_type body;
      bit            drain_first;
   } pending_beat_type;

   // One expected line bit
   typedef struct packed {
      logic line_bit;
      logic run_end;
   } line_bit_type;

   localparam int BEATS_WANTED = 480;
   localparam int RECV_HOLD_AT = 1500;
   localparam int RECV_HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hbsf_req_if req_ch();
   hbsf_rsp_if rsp_ch();

   hdlc_bit_stuffing_framer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pending_beat_type pending_beats[$];
   line_bit_type     line_expect[$];
   hbsf_item_type    in_flight;
   logic [2:0]       ones_run_model = 3'd0;
   int               failures = 0;

   // Clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Draw a wait for one beat; each stretch is calm or busy at random
   function automatic int draw_wait(inout int stretch, inout bit calm);
      if (stretch == 0) begin
         stretch = $urandom_range(20, 120);
         calm = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // Work out the line bits that one beat produces and queue them
   task automatic predict_line_bits(input hbsf_item_type beat);
      logic bits[$];
      int   n_bits;
      int   k;
      logic b;
      line_bit_type lb;
      n_bits = (beat.bit_count > BYTE_BITS) ? int'(BYTE_BITS) : int'(beat.bit_count);
      // opening flag, ones run restarts
      if (beat.frame_first) begin
         for (k = 0; k < 8; k++) bits.push_back(FLAG_PATTERN[7 - k]);
         ones_run_model = 3'd0;
      end
      // body bits with zero insertion after five ones
      for (k = 0; k < n_bits; k++) begin
         b = beat.data_byte[7 - k];
         bits.push_back(b);
         if (b) begin
            ones_run_model = ones_run_model + 3'd1;
            if (ones_run_model >= STUFF_LIMIT) begin
               bits.push_back(1'b0);
               ones_run_model = 3'd0;
            end
         end else begin
            ones_run_model = 3'd0;
         end
      end
      // closing flag is never stuffed
      if (beat.frame_last) begin
         for (k = 0; k < 8; k++) bits.push_back(FLAG_PATTERN[7 - k]);
         ones_run_model = 3'd0;
      end
      for (k = 0; k < bits.size(); k++) begin
         lb.line_bit = bits[k];
         lb.run_end = (k == bits.size() - 1);
         line_expect.push_back(lb);
      end
   endtask

   task automatic add_beat(input logic [7:0] d, input logic [3:0] c, input logic f,
                           input logic l, input bit drain);
      pending_beat_type pb;
      pb.body.data_byte = d;
      pb.body.bit_count = c;
      pb.body.frame_first = f;
      pb.body.frame_last = l;
      pb.drain_first = drain;
      pending_beats.push_back(pb);
   endtask

   // Frame body bytes lean toward long runs of ones
   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 3))
         0: return 8'hFF;
         1: return 8'($urandom_range(0, 255) | $urandom_range(0, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Driver: offer queued beats, predict each one as it is taken
   int  send_stretch = 0;
   bit  send_calm = 1'b0;
   int  send_gap = 0;
   always @(posedge clock) begin
      logic             offer;
      pending_beat_type next_beat;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            predict_line_bits(in_flight);
            offer = 1'b0;
            send_gap = draw_wait(send_stretch, send_calm);
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].drain_first && line_expect.size() != 0)) begin
               next_beat = pending_beats.pop_front();
               in_flight = next_beat.body;
               req_ch.data_byte <= in_flight.data_byte;
               req_ch.bit_count <= in_flight.bit_count;
               req_ch.frame_first <= in_flight.frame_first;
               req_ch.frame_last <= in_flight.frame_last;
               offer = 1'b1;
            end
         end
         req_ch.valid <= offer;
      end
   end

   // Monitor: take line bits, compare against the oldest expectation
   int  recv_stretch = 0;
   bit  recv_calm = 1'b0;
   int  recv_gap = 0;
   int  recv_hold = 0;
   int  bits_taken = 0;
   always @(posedge clock) begin
      logic         take;
      line_bit_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (line_expect.size() == 0) begin
               $display("%0t: unexpected line beat line_bit=%b run_end=%b",
                        $time, rsp_ch.line_bit, rsp_ch.run_end);
               failures++;
            end else begin
               want = line_expect.pop_front();
               if (rsp_ch.line_bit !== want.line_bit) begin
                  $display("%0t: line_bit expected %b actual %b",
                           $time, want.line_bit, rsp_ch.line_bit);
                  failures++;
               end
               if (rsp_ch.run_end !== want.run_end) begin
                  $display("%0t: run_end expected %b actual %b",
                           $time, want.run_end, rsp_ch.run_end);
                  failures++;
               end
            end
            bits_taken++;
            recv_gap = draw_wait(recv_stretch, recv_calm);
            // long back-pressure so the input queue fills up
            if (bits_taken == RECV_HOLD_AT) recv_hold = RECV_HOLD_CYCLES;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            take = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_ch.ready <= take;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int  beats_planned;
      int  body_len;
      int  k;
      bit  drain_done;
      logic [3:0] c;
      logic f;
      logic l;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.bit_count = 4'd0;
      req_ch.frame_first = 1'b0;
      req_ch.frame_last = 1'b0;
      rsp_ch.ready = 1'b0;

      // Directed beats
      add_beat(8'hFF, 4'd8, 1'b1, 1'b1, 1'b0);   // first and last together, stuffing
      add_beat(8'h7E, 4'd8, 1'b1, 1'b0, 1'b0);   // flag pattern inside the body
      add_beat(8'h1F, 4'd8, 1'b0, 1'b0, 1'b0);   // fifth one on the final bit
      add_beat(8'hF8, 4'd5, 1'b0, 1'b1, 1'b0);   // stuffed zero before closing flag
      add_beat(8'hC0, 4'd2, 1'b0, 1'b0, 1'b0);   // body with no opening flag
      add_beat(8'hE0, 4'd3, 1'b0, 1'b0, 1'b0);   // ones run carries over
      add_beat(8'hFF, 4'd0, 1'b0, 1'b0, 1'b0);   // no bits, no flags: nothing out
      add_beat(8'hFF, 4'd0, 1'b1, 1'b0, 1'b0);   // opening flag only
      add_beat(8'h00, 4'd0, 1'b0, 1'b1, 1'b0);   // closing flag only
      add_beat(8'hFF, 4'd0, 1'b1, 1'b1, 1'b0);   // both flags, no body
      add_beat(8'hAA, 4'd15, 1'b1, 1'b0, 1'b0);  // count above eight
      add_beat(8'hFF, 4'd9, 1'b0, 1'b0, 1'b0);
      add_beat(8'h80, 4'd1, 1'b0, 1'b0, 1'b0);
      add_beat(8'h7F, 4'd1, 1'b0, 1'b0, 1'b0);
      add_beat(8'hF0, 4'd4, 1'b0, 1'b0, 1'b0);
      add_beat(8'hF8, 4'd8, 1'b0, 1'b0, 1'b0);
      add_beat(8'h00, 4'd8, 1'b0, 1'b1, 1'b0);
      add_beat(8'h55, 4'd12, 1'b1, 1'b0, 1'b1);  // sender waits for the line to drain
      add_beat(8'hFF, 4'd7, 1'b0, 1'b1, 1'b0);
      beats_planned = 18;

      // Random frames with some noise beats in between
      drain_done = 1'b0;
      while (beats_planned < BEATS_WANTED) begin
         if ($urandom_range(0, 9) < 7) begin
            body_len = $urandom_range(2, 8);
            for (k = 0; k < body_len; k++) begin
               c = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(1, 8)) : 4'd8;
               add_beat(body_byte(), c, k == 0, k == body_len - 1,
                        !drain_done && beats_planned >= BEATS_WANTED / 2 && k == 0);
               if (beats_planned >= BEATS_WANTED / 2 && k == 0) drain_done = 1'b1;
               beats_planned++;
            end
         end else begin
            c = 4'($urandom_range(0, 15));
            f = 1'($urandom_range(0, 1));
            l = 1'($urandom_range(0, 1));
            add_beat(8'($urandom_range(0, 255)), c, f, l, 1'b0);
            if (c != 4'd0 || f || l) beats_planned++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_ch.valid) @(posedge clock);
      while (line_expect.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
